[sv/mss_pkg.sv]
// ----------------------------------------------------------------------------
// mss_pkg
// Types, codes and constants shared by the motor speed sequencer modules.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int unsigned PROGRAM_DEPTH_DEF = 64;
  localparam int unsigned SPEED_W           = 8;
  localparam int unsigned LEN_W             = 16;
  localparam int unsigned OP_W              = 4;
  localparam int unsigned COUNT_OUT_W       = 7;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned S_TDATA_W         = 32;
  localparam int unsigned M_TDATA_W         = 40;
  localparam int unsigned CFG_IDX_W         = 1;

  localparam logic [SPEED_W-1:0] MIN_SPEED_RST = 8'd60;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 1'b1;

  localparam logic [OP_W-1:0] OP_TICK   = 4'd0;
  localparam logic [OP_W-1:0] OP_SET    = 4'd1;
  localparam logic [OP_W-1:0] OP_TIMED  = 4'd2;
  localparam logic [OP_W-1:0] OP_LIMITS = 4'd3;
  localparam logic [OP_W-1:0] OP_LED    = 4'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 4'd5;
  localparam logic [OP_W-1:0] OP_ADD    = 4'd6;
  localparam logic [OP_W-1:0] OP_START  = 4'd7;
  localparam logic [OP_W-1:0] OP_STOP   = 4'd8;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_SPEED   = 2'd1,
    MODE_TIMED   = 2'd2,
    MODE_PROGRAM = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    KIND_TICK,
    KIND_SET,
    KIND_TIMED,
    KIND_LIMITS,
    KIND_LED,
    KIND_CLEAR,
    KIND_ADD,
    KIND_START,
    KIND_STOP,
    KIND_NONE
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [SPEED_W-1:0] speed;
    logic [LEN_W-1:0]   len;
    logic               led;
  } item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_min;
    logic [SPEED_W-1:0] speed_max;
  } limits_t;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [SPEED_W-1:0] speed;
  } entry_t;

  typedef struct packed {
    logic [SPEED_W-1:0]     duty;
    logic                   led;
    mode_e                  mode;
    logic [COUNT_OUT_W-1:0] count;
    logic                   reply;
    logic [SPEED_W-1:0]     reply_min;
    logic [SPEED_W-1:0]     reply_max;
  } result_t;

endpackage

[sv/mss_ram.sv]
// ----------------------------------------------------------------------------
// mss_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module mss_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/mss_front.sv]
// ----------------------------------------------------------------------------
// mss_front
// Speed limits, command decode, out-of-range speed zeroing ahead of the queue.
// ----------------------------------------------------------------------------
module mss_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mss_pkg::SPEED_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mss_pkg::OP_W-1:0]      op_i,
  input  logic [mss_pkg::SPEED_W-1:0]   speed_req_i,
  input  logic [mss_pkg::LEN_W-1:0]     run_length_i,
  input  logic                          led_on_i,
  input  logic                          full_i,
  output logic                          push_o,
  output mss_pkg::item_t                item_o,
  output mss_pkg::limits_t              limits_o
);
  import mss_pkg::*;

  logic [SPEED_W-1:0] min_q, max_q;
  kind_e              kind;
  logic               in_range;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_SPEED_RST;
      max_q <= MAX_SPEED_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_SPEED: min_q <= cfg_data_i;
        CFG_MAX_SPEED: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (op_i)
      OP_TICK:   kind = KIND_TICK;
      OP_SET:    kind = KIND_SET;
      OP_TIMED:  kind = KIND_TIMED;
      OP_LIMITS: kind = KIND_LIMITS;
      OP_LED:    kind = KIND_LED;
      OP_CLEAR:  kind = KIND_CLEAR;
      OP_ADD:    kind = KIND_ADD;
      OP_START:  kind = KIND_START;
      OP_STOP:   kind = KIND_STOP;
      default:   kind = KIND_NONE;
    endcase
  end

  assign in_range = (speed_req_i >= min_q) && (speed_req_i <= max_q);

  assign in_ready_o  = !full_i;
  assign push_o      = in_valid_i && !full_i;
  assign item_o.kind  = kind;
  assign item_o.speed = in_range ? speed_req_i : '0;
  assign item_o.len   = run_length_i;
  assign item_o.led   = led_on_i;

  assign limits_o.speed_min = min_q;
  assign limits_o.speed_max = max_q;

endmodule

[sv/mss_queue.sv]
// ----------------------------------------------------------------------------
// mss_queue
// Short command queue between the decode front and the execution back end.
// ----------------------------------------------------------------------------
module mss_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mss_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output mss_pkg::item_t item_o
);
  import mss_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

[sv/mss_back.sv]
// ----------------------------------------------------------------------------
// mss_back
// Executes queued commands on the duty, mode and program state and registers
// one result beat per command.
// ----------------------------------------------------------------------------
module mss_back #(
  parameter int unsigned PROGRAM_DEPTH = mss_pkg::PROGRAM_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  mss_pkg::item_t   item_i,
  output logic             pop_o,
  input  mss_pkg::limits_t limits_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mss_pkg::result_t result_o
);
  import mss_pkg::*;

  localparam int unsigned AW = $clog2(PROGRAM_DEPTH);
  localparam int unsigned CW = $clog2(PROGRAM_DEPTH + 1);
  localparam int unsigned EW = $bits(entry_t);

  logic [SPEED_W-1:0] duty_q, duty_d;
  logic [LEN_W-1:0]   ticks_q, ticks_d;
  mode_e              mode_q, mode_d;
  logic [CW-1:0]      step_q, step_d;
  logic [CW-1:0]      count_q, count_d;
  logic               led_q, led_d;
  entry_t             first_q, first_d;
  logic               out_valid_q;
  result_t            result_q, result_d;

  entry_t             new_entry, next_entry;
  logic [EW-1:0]      rdata;
  logic               we;
  logic               editable;

  assign pop_o     = !empty_i && (!out_valid_q || out_ready_i);
  assign new_entry = '{len: item_i.len, speed: item_i.speed};
  assign next_entry = entry_t'(rdata);
  assign editable  = (mode_q != MODE_PROGRAM);

  mss_ram #(
    .WIDTH(EW),
    .DEPTH(PROGRAM_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(new_entry),
    .raddr_i(step_d[AW-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    duty_d  = duty_q;
    ticks_d = ticks_q;
    mode_d  = mode_q;
    step_d  = step_q;
    count_d = count_q;
    led_d   = led_q;
    first_d = first_q;
    we      = 1'b0;
    if (pop_o) begin
      case (item_i.kind)
        KIND_TICK: begin
          if (mode_q == MODE_TIMED) begin
            if (ticks_q == '0) begin
              duty_d = '0;
            end else begin
              ticks_d = ticks_q - LEN_W'(1);
            end
          end else if (mode_q == MODE_PROGRAM) begin
            if (ticks_q != '0) begin
              ticks_d = ticks_q - LEN_W'(1);
            end else if (step_q < count_q) begin
              duty_d  = next_entry.speed;
              ticks_d = next_entry.len;
              step_d  = step_q + CW'(1);
            end
          end
        end
        KIND_SET: begin
          mode_d = MODE_SPEED;
          duty_d = item_i.speed;
        end
        KIND_TIMED: begin
          mode_d  = MODE_TIMED;
          duty_d  = item_i.speed;
          ticks_d = item_i.len;
        end
        KIND_LED: led_d = item_i.led;
        KIND_CLEAR: begin
          if (editable) begin
            count_d = '0;
          end
        end
        KIND_ADD: begin
          if (editable && (count_q < CW'(PROGRAM_DEPTH))) begin
            we      = 1'b1;
            count_d = count_q + CW'(1);
            if (count_q == '0) begin
              first_d = new_entry;
            end
          end
        end
        KIND_START: begin
          if (editable && (count_q != '0)) begin
            mode_d  = MODE_PROGRAM;
            duty_d  = first_q.speed;
            ticks_d = first_q.len;
            step_d  = CW'(1);
          end
        end
        KIND_STOP: begin
          mode_d = MODE_SPEED;
          duty_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result_d.duty      = duty_d;
    result_d.led       = led_d;
    result_d.mode      = mode_d;
    result_d.count     = COUNT_OUT_W'(count_d);
    result_d.reply     = (item_i.kind == KIND_LIMITS);
    result_d.reply_min = (item_i.kind == KIND_LIMITS) ? limits_i.speed_min : '0;
    result_d.reply_max = (item_i.kind == KIND_LIMITS) ? limits_i.speed_max : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q      <= '0;
      ticks_q     <= '0;
      mode_q      <= MODE_OFF;
      step_q      <= '0;
      count_q     <= '0;
      led_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      duty_q  <= duty_d;
      ticks_q <= ticks_d;
      mode_q  <= mode_d;
      step_q  <= step_d;
      count_q <= count_d;
      led_q   <= led_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    if (pop_o) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

[sv/motor_speed_sequencer_core.sv]
// a taken input beat is queued, then the back end registers its result beat
// throughput: one command or tick per cycle when not stalled, held by the single
// back end execution stage that reads the program store once per cycle
// the next program entry is prefetched from the store's registered read port
// reset clears duty, mode, counts, led and limits (60 and 255) at once;
// program store contents are undefined until written
// ----------------------------------------------------------------------------
// motor_speed_sequencer_core
// PWM speed sequencer: fixed, timed and programmed duty from commands and ticks.
// ----------------------------------------------------------------------------
module motor_speed_sequencer_core #(
  parameter int unsigned PROGRAM_DEPTH = mss_pkg::PROGRAM_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mss_pkg::SPEED_W-1:0]   cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // speed_req, run_length, led_on, zero padding
  input  logic [mss_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // op
  input  logic [mss_pkg::OP_W-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // duty, led_level, mode_now, program_count, reply_min, reply_max, zero padding
  output logic [mss_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // reply_valid
  output logic                          m_axis_tuser
);
  import mss_pkg::*;

  item_t   push_item, pop_item;
  limits_t limits;
  result_t res;
  logic    push, pop, full, empty;

  mss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .speed_req_i (s_axis_tdata[SPEED_W-1:0]),
    .run_length_i(s_axis_tdata[SPEED_W+LEN_W-1:SPEED_W]),
    .led_on_i    (s_axis_tdata[SPEED_W+LEN_W]),
    .full_i      (full),
    .push_o      (push),
    .item_o      (push_item),
    .limits_o    (limits)
  );

  mss_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .item_o (pop_item)
  );

  mss_back #(
    .PROGRAM_DEPTH(PROGRAM_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .item_i     (pop_item),
    .pop_o      (pop),
    .limits_i   (limits),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .result_o   (res)
  );

  assign m_axis_tdata = M_TDATA_W'({res.reply_max, res.reply_min, res.count,
                                    res.mode, res.led, res.duty});
  assign m_axis_tuser = res.reply;

endmodule

[sv/mss_checker.sv]
// ----------------------------------------------------------------------------
// mss_checker
// Port level checks on the sequencer result stream, bound to the top level.
// ----------------------------------------------------------------------------
module mss_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mss_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);
  import mss_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_reply_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[33:18] == 16'd0)
    else $error("limits fields set without a reply");

  a_off_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[10:9] == MODE_OFF |-> m_axis_tdata[7:0] == 8'd0)
    else $error("non-zero duty while off");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result beat without a matching input beat");

endmodule

bind motor_speed_sequencer_core mss_checker u_mss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
